@@ hw/rtl/wsfu_pkg.sv @@
// ----------------------------------------------------------------------------
// wsfu_pkg
// Types and codes shared by the frame unmasker modules.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  // Header / payload parse phase, one-hot
  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT_HI  = 7'b0000100,
    PH_EXT_LO  = 7'b0001000,
    PH_KEY     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_IGNORE  = 7'b1000000
  } phase_e;

  // Frame opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Frame status codes
  localparam logic [1:0] ST_TEXT_OK = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_CLOSING = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // Header constants
  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;
  localparam int unsigned KEY_BYTES = 4;

  // One result word
  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [1:0] frame_status;
  } result_t;

endpackage

@@ hw/rtl/wsfu_parser.sv @@
// ----------------------------------------------------------------------------
// wsfu_parser
// Header parser state and payload unmasking for one registered input byte.
// ----------------------------------------------------------------------------
module wsfu_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,    // consume the registered byte
  input  logic [7:0]        rx_byte_i,
  input  logic              last_i,
  output logic              has_result_o,
  output wsfu_pkg::result_t result_o
);
  import wsfu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        error_q, error_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [31:0] key_q, key_d;

  logic [15:0] count_inc;
  logic        op_known;
  logic        dv;
  logic [7:0]  pb;
  logic [7:0]  key_byte;
  logic [1:0]  status;

  assign count_inc = count_q + 16'd1;
  assign op_known  = (rx_byte_i[3:0] == OP_TEXT)  || (rx_byte_i[3:0] == OP_BINARY) ||
                     (rx_byte_i[3:0] == OP_CLOSE) || (rx_byte_i[3:0] == OP_PING)   ||
                     (rx_byte_i[3:0] == OP_PONG);

  // key byte for this payload position, first key byte first
  always_comb begin
    case (count_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    error_d  = error_q;
    length_d = length_q;
    count_d  = count_q;
    key_d    = key_q;
    dv       = 1'b0;
    pb       = 8'h00;
    unique case (phase_q)
      PH_HDR0: begin
        opcode_d = rx_byte_i[3:0];
        if ((rx_byte_i[6:4] != 3'b000) || !rx_byte_i[7] || !op_known) begin
          error_d = 1'b1;
          phase_d = PH_IGNORE;
        end else begin
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (rx_byte_i[6:0] == LEN_EXT16) begin
          phase_d = PH_EXT_HI;
        end else if (rx_byte_i[6:0] == LEN_EXT64) begin
          if (opcode_q == OP_TEXT) error_d = 1'b1;
          phase_d = PH_IGNORE;
        end else begin
          length_d = {9'd0, rx_byte_i[6:0]};
          count_d  = 16'd0;
          phase_d  = PH_KEY;
        end
      end
      PH_EXT_HI: begin
        length_d = {rx_byte_i, 8'h00};
        phase_d  = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        length_d = {length_q[15:8], rx_byte_i};
        count_d  = 16'd0;
        phase_d  = PH_KEY;
      end
      PH_KEY: begin
        key_d   = {key_q[23:0], rx_byte_i};
        count_d = count_inc;
        if (count_inc >= 16'(KEY_BYTES)) begin
          count_d = 16'd0;
          phase_d = (length_q != 16'd0) ? PH_PAYLOAD : PH_IGNORE;
        end
      end
      PH_PAYLOAD: begin
        if (opcode_q == OP_TEXT) begin
          dv = 1'b1;
          pb = rx_byte_i ^ key_byte;
        end
        count_d = count_inc;
        if (count_inc >= length_q) phase_d = PH_IGNORE;
      end
      default: ;
    endcase
  end

  // status from the updated phase and flags
  always_comb begin
    if (error_d || (phase_d != PH_IGNORE)) status = ST_ERROR;
    else if (opcode_d == OP_TEXT)          status = ST_TEXT_OK;
    else if (opcode_d == OP_CLOSE)         status = ST_CLOSING;
    else                                   status = ST_IGNORED;
  end

  assign has_result_o          = dv || last_i;
  assign result_o.data_valid   = dv;
  assign result_o.payload_byte = pb;
  assign result_o.frame_done   = last_i;
  assign result_o.frame_status = last_i ? status : ST_TEXT_OK;

  // state registers; the buffer's last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= 4'h0;
      error_q  <= 1'b0;
      length_q <= 16'd0;
      count_q  <= 16'd0;
      key_q    <= 32'd0;
    end else if (advance_i) begin
      if (last_i) begin
        phase_q  <= PH_HDR0;
        opcode_q <= 4'h0;
        error_q  <= 1'b0;
        length_q <= 16'd0;
        count_q  <= 16'd0;
        key_q    <= 32'd0;
      end else begin
        phase_q  <= phase_d;
        opcode_q <= opcode_d;
        error_q  <= error_d;
        length_q <= length_d;
        count_q  <= count_d;
        key_q    <= key_d;
      end
    end
  end

endmodule

@@ hw/rtl/wsfu_out_buf.sv @@
// ----------------------------------------------------------------------------
// wsfu_out_buf
// Result register with a skid stage, so the parser can hand over one more
// result after the receiver stalls.
// ----------------------------------------------------------------------------
module wsfu_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfu_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output wsfu_pkg::result_t data_o
);
  import wsfu_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop, push;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign pop     = main_valid_q && pop_ready_i;
  assign push    = push_i && !skid_valid_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) skid_valid_q <= 1'b0;
      else              main_valid_q <= push;
    end else if (push) begin
      if (main_valid_q) skid_valid_q <= 1'b1;
      else              main_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) main_q <= skid_q;
      else if (push)    main_q <= push_data_i;
    end else if (push) begin
      if (main_valid_q) skid_q <= push_data_i;
      else              main_q <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/websocket_frame_unmasker.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses one received client frame a byte per word and unmasks text payload.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one frame buffer byte per word in s_axis_tdata, with
//   s_axis_tlast on the buffer's final byte. Master channel: one word per
//   unmasked text byte and one on the buffer's final byte (both may share a
//   word). m_axis_tuser bit 0 flags a valid payload byte in m_axis_tdata;
//   m_axis_tlast marks the final word and m_axis_tuser[2:1] then holds the
//   frame status (text ok, ignored, closing, error).
//   Bytes that produce nothing (header, key, ignored payload) are absorbed.
//   Throughput: one byte per cycle while the receiver keeps up, set by the
//   single parser state update. An accepted byte is held in the input
//   register; its result word is then written into the result register
//   (or the skid stage) when the parser consumes it.
//   Reset clears the parser to expect a first header byte and empties the
//   input and result registers. When the receiver stalls, the skid stage
//   takes one more result and the input register holds one more byte;
//   after that s_axis_tready drops until the receiver drains.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tlast,   // end_of_buffer
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_done
  output logic [2:0] m_axis_tuser    // [0] data_valid, [2:1] frame_status
);
  import wsfu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       buf_ready;
  logic       has_result;
  result_t    result;
  result_t    out_word;

  assign advance       = in_valid_q && buf_ready;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  wsfu_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .rx_byte_i    (in_byte_q),
    .last_i       (in_last_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  wsfu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && has_result),
    .push_data_i (result),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_word)
  );

  assign m_axis_tdata = out_word.payload_byte;
  assign m_axis_tlast = out_word.frame_done;
  assign m_axis_tuser = {out_word.frame_status, out_word.data_valid};

  // every word carries a payload byte or closes the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
    else $error("result word with neither payload nor frame end");

  // status only on the closing word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_TEXT_OK))
    else $error("frame status set on a non-final word");

  // no payload bits without a valid payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
    else $error("payload byte nonzero while not valid");

  // a full skid stage only exists behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !buf_ready |-> m_axis_tvalid)
    else $error("skid stage full with empty result register");

endmodule
